// ----- sv/wphsc_pkg.sv -----
// Package for the waypoint heading and speed controller.
// Payload, configuration, command and status types, fixed-point constants, arctangent table.
// No dependencies.
`default_nettype none

package wphsc_pkg;

  localparam int unsigned CORDIC_STEPS = 14;
  localparam int unsigned ITER_W       = 4;

  localparam logic signed [17:0] PI_Q      = 18'sd25736;
  localparam logic signed [17:0] HALF_PI_Q = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q  = 18'sd51472;
  localparam logic signed [39:0] NEAR_Q    = 40'sd66;
  localparam logic signed [16:0] INV_GAIN  = 17'sd39797;
  localparam logic signed [39:0] REACH_DISTANCE = 40'sd19661;

  // register indexes
  localparam logic [2:0] REG_HDG_KP  = 3'd0;
  localparam logic [2:0] REG_HDG_KI  = 3'd1;
  localparam logic [2:0] REG_HDG_KD  = 3'd2;
  localparam logic [2:0] REG_LIN_KP  = 3'd3;
  localparam logic [2:0] REG_MAX_LIN = 3'd4;
  localparam logic [2:0] REG_MAX_ANG = 3'd5;
  localparam logic [2:0] REG_MIN_LIN = 3'd6;
  localparam logic [2:0] REG_MIN_ANG = 3'd7;

  typedef struct packed {
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] robot_heading;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [15:0] target_heading;
    logic               rotate_only;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] angular_speed;
    logic signed [15:0] linear_speed;
  } out_item_t;

  typedef struct packed {
    logic [15:0] hdg_kp;
    logic [15:0] hdg_ki;
    logic [15:0] hdg_kd;
    logic [15:0] lin_kp;
    logic [14:0] max_linear_speed;
    logic [14:0] max_angular_speed;
    logic [14:0] min_linear_speed;
    logic [14:0] min_angular_speed;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_X, MUL_Y, MUL_ERR, MUL_INT, MUL_DER, MUL_DIST
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRE, ST_ROT, ST_UGX, ST_UGY, ST_WBY, ST_VINIT, ST_VEC,
    ST_VUG, ST_VWB, ST_PK, ST_PI, ST_PD, ST_PACC, ST_OUT
  } state_e;

  typedef struct packed {
    logic     load_in;
    logic     pre_rot;
    logic     rot_step;
    logic     vec_init;
    logic     vec_step;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     wb_x;
    logic     wb_y;
    logic     wb_dist;
    logic     acc_load;
    logic     acc_add;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic iter_last;
    logic out_full;
  } status_t;

  function automatic logic signed [17:0] atan_tab(input logic [ITER_W-1:0] i);
    logic signed [17:0] r;
    unique case (i)
      4'd0:    r = 18'sd6434;
      4'd1:    r = 18'sd3798;
      4'd2:    r = 18'sd2007;
      4'd3:    r = 18'sd1019;
      4'd4:    r = 18'sd511;
      4'd5:    r = 18'sd256;
      4'd6:    r = 18'sd128;
      4'd7:    r = 18'sd64;
      4'd8:    r = 18'sd32;
      4'd9:    r = 18'sd16;
      4'd10:   r = 18'sd8;
      4'd11:   r = 18'sd4;
      4'd12:   r = 18'sd2;
      4'd13:   r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] wrap_angle(input logic signed [17:0] e);
    logic signed [17:0] r;
    if (e > PI_Q) begin
      r = e - TWO_PI_Q;
    end else if (e < -PI_Q) begin
      r = e + TWO_PI_Q;
    end else begin
      r = e;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/waypoint_heading_speed_controller.sv -----
// Waypoint heading and speed controller, top level.
// One request in flight: a new request is accepted only in idle, after the previous result
// has been loaded into the output register. Two 14-step CORDIC passes share one shift-add
// unit and seven products share one multiplier; output stalls hold the sequencer.
// Reset clears the PID integral, previous error, handshake state and loads register defaults.
// Depends on wphsc_pkg, wphsc_regs, wphsc_ctrl, wphsc_dp.
`default_nettype none

module waypoint_heading_speed_controller (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire wphsc_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output wphsc_pkg::out_item_t      out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import wphsc_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  wphsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wphsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wphsc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- sv/wphsc_regs.sv -----
// APB-style configuration registers of the controller.
// Depends on wphsc_pkg.
`default_nettype none

module wphsc_regs (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output wphsc_pkg::cfg_t          cfg_o
);
  import wphsc_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdg_kp            <= 16'd1280;
      cfg_q.hdg_ki            <= 16'd0;
      cfg_q.hdg_kd            <= 16'd51;
      cfg_q.lin_kp            <= 16'd256;
      cfg_q.max_linear_speed  <= 15'd563;
      cfg_q.max_angular_speed <= 15'd307;
      cfg_q.min_linear_speed  <= 15'd128;
      cfg_q.min_angular_speed <= 15'd102;
    end else if (wr) begin
      unique case (idx)
        REG_HDG_KP:  cfg_q.hdg_kp            <= pwdata[15:0];
        REG_HDG_KI:  cfg_q.hdg_ki            <= pwdata[15:0];
        REG_HDG_KD:  cfg_q.hdg_kd            <= pwdata[15:0];
        REG_LIN_KP:  cfg_q.lin_kp            <= pwdata[15:0];
        REG_MAX_LIN: cfg_q.max_linear_speed  <= pwdata[14:0];
        REG_MAX_ANG: cfg_q.max_angular_speed <= pwdata[14:0];
        REG_MIN_LIN: cfg_q.min_linear_speed  <= pwdata[14:0];
        REG_MIN_ANG: cfg_q.min_angular_speed <= pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HDG_KP:  prdata = {16'd0, cfg_q.hdg_kp};
      REG_HDG_KI:  prdata = {16'd0, cfg_q.hdg_ki};
      REG_HDG_KD:  prdata = {16'd0, cfg_q.hdg_kd};
      REG_LIN_KP:  prdata = {16'd0, cfg_q.lin_kp};
      REG_MAX_LIN: prdata = {17'd0, cfg_q.max_linear_speed};
      REG_MAX_ANG: prdata = {17'd0, cfg_q.max_angular_speed};
      REG_MIN_LIN: prdata = {17'd0, cfg_q.min_linear_speed};
      REG_MIN_ANG: prdata = {17'd0, cfg_q.min_angular_speed};
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/wphsc_ctrl.sv -----
// Sequencer for the controller: CORDIC rotate, vectoring, PID and output steps.
// Depends on wphsc_pkg.
`default_nettype none

module wphsc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire wphsc_pkg::status_t status_i,
  output wphsc_pkg::cmd_t        cmd_o
);
  import wphsc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_X;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd_o.pre_rot = 1'b1;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        cmd_o.rot_step = 1'b1;
        if (status_i.iter_last) state_d = ST_UGX;
      end
      ST_UGX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_X;
        state_d = ST_UGY;
      end
      ST_UGY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Y;
        cmd_o.wb_x    = 1'b1;
        state_d = ST_WBY;
      end
      ST_WBY: begin
        cmd_o.wb_y = 1'b1;
        state_d = ST_VINIT;
      end
      ST_VINIT: begin
        cmd_o.vec_init = 1'b1;
        state_d = ST_VEC;
      end
      ST_VEC: begin
        cmd_o.vec_step = 1'b1;
        if (status_i.iter_last) state_d = ST_VUG;
      end
      ST_VUG: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_X;
        state_d = ST_VWB;
      end
      ST_VWB: begin
        cmd_o.wb_dist = 1'b1;
        state_d = ST_PK;
      end
      ST_PK: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ERR;
        state_d = ST_PI;
      end
      ST_PI: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_INT;
        cmd_o.acc_load = 1'b1;
        state_d = ST_PD;
      end
      ST_PD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DER;
        cmd_o.acc_add = 1'b1;
        state_d = ST_PACC;
      end
      ST_PACC: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DIST;
        cmd_o.acc_add = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register can take the result
        if (!status_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/wphsc_dp.sv -----
// Datapath: shared CORDIC registers, one shared multiplier, PID state, output register.
// Depends on wphsc_pkg.
`default_nettype none

module wphsc_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire wphsc_pkg::in_item_t  in_data_i,
  input  wire wphsc_pkg::cfg_t      cfg_i,
  input  wire wphsc_pkg::cmd_t      cmd_i,
  output wphsc_pkg::status_t        status_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output wphsc_pkg::out_item_t      out_data_o
);
  import wphsc_pkg::*;

  logic signed [39:0] x_q, y_q, dist_q;
  logic signed [17:0] z_q;
  logic [ITER_W-1:0]  iter_q;
  logic signed [15:0] rerr_q, err_q, prev_q;
  logic signed [16:0] der_q;
  logic signed [31:0] int_q;
  logic               rot_q, near_q, fwd_q;
  logic signed [57:0] p_q;
  logic signed [51:0] acc_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // barrel shifts and table entry for the current CORDIC step
  logic signed [39:0] xs, ys;
  logic signed [17:0] at;
  assign xs = x_q >>> iter_q;
  assign ys = y_q >>> iter_q;
  assign at = atan_tab(iter_q);

  // shared multiplier
  logic signed [40:0] mul_a;
  logic signed [16:0] mul_b;
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_X:    begin mul_a = 41'(x_q);    mul_b = INV_GAIN; end
      MUL_Y:    begin mul_a = 41'(y_q);    mul_b = INV_GAIN; end
      MUL_ERR:  begin mul_a = 41'(err_q);  mul_b = {1'b0, cfg_i.hdg_kp}; end
      MUL_INT:  begin mul_a = 41'(int_q);  mul_b = {1'b0, cfg_i.hdg_ki}; end
      MUL_DER:  begin mul_a = 41'(der_q);  mul_b = {1'b0, cfg_i.hdg_kd}; end
      MUL_DIST: begin mul_a = 41'(dist_q); mul_b = {1'b0, cfg_i.lin_kp}; end
      default:  begin mul_a = '0;          mul_b = '0; end
    endcase
  end

  logic signed [57:0] rnd;
  logic signed [39:0] ungain;
  assign rnd    = p_q + 58'sd32768;
  assign ungain = rnd[55:16];

  // load-time values
  logic signed [17:0] ryaw_w, th0, rerr_w;
  assign ryaw_w = wrap_angle(18'(in_data_i.robot_heading));
  assign th0    = -ryaw_w;
  assign rerr_w = wrap_angle(18'(in_data_i.target_heading) - 18'(in_data_i.robot_heading));

  // vectoring setup
  logic near_w;
  assign near_w = (x_q < NEAR_Q) && (x_q > -NEAR_Q);

  // heading error and integral
  logic signed [17:0] hd, hfold;
  logic signed [15:0] err_w;
  logic signed [32:0] int_sum;
  logic signed [31:0] int_w;
  always_comb begin
    if (near_q) begin
      hd = fwd_q ? HALF_PI_Q : -HALF_PI_Q;
    end else begin
      hd = z_q;
    end
    if (hd > HALF_PI_Q) begin
      hfold = hd - PI_Q;
    end else if (hd < -HALF_PI_Q) begin
      hfold = hd + PI_Q;
    end else begin
      hfold = hd;
    end
    err_w   = rot_q ? rerr_q : hfold[15:0];
    int_sum = 33'(int_q) + 33'(err_w);
    if (int_sum[32] != int_sum[31]) begin
      int_w = int_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      int_w = int_sum[31:0];
    end
  end

  // result formatting
  logic signed [51:0] acc_r;
  logic signed [38:0] ang;
  logic               ang_neg, lin_neg, lin_on;
  logic [38:0]        ang_mag;
  logic [14:0]        ang_c, lin_c;
  logic [41:0]        lin_mag;
  logic signed [15:0] ang_o, lin_o;
  always_comb begin
    acc_r   = acc_q + 52'sd4096;
    ang     = acc_r[51:13];
    ang_neg = ang < 0;
    ang_mag = ang_neg ? 39'(-ang) : 39'(ang);
    if (ang_mag >= 39'(cfg_i.max_angular_speed)) begin
      ang_c = cfg_i.max_angular_speed;
    end else if (ang_mag < 39'(cfg_i.min_angular_speed)) begin
      ang_c = cfg_i.min_angular_speed;
    end else begin
      ang_c = ang_mag[14:0];
    end
    if (rot_q) begin
      ang_o = ang_neg ? -$signed({1'b0, ang_c}) : $signed({1'b0, ang_c});
    end else if (ang > 39'sd32767) begin
      ang_o = 16'sh7FFF;
    end else if (ang < -39'sd32768) begin
      ang_o = 16'sh8000;
    end else begin
      ang_o = ang[15:0];
    end

    lin_mag = rnd[57:16];
    if (lin_mag >= 42'(cfg_i.max_linear_speed)) begin
      lin_c = cfg_i.max_linear_speed;
    end else if (lin_mag < 42'(cfg_i.min_linear_speed)) begin
      lin_c = cfg_i.min_linear_speed;
    end else begin
      lin_c = lin_mag[14:0];
    end
    // zero magnitude keeps the positive sign
    lin_neg = !fwd_q && (lin_mag != '0);
    lin_on  = !rot_q && (dist_q > REACH_DISTANCE);
    if (!lin_on) begin
      lin_o = '0;
    end else begin
      lin_o = lin_neg ? -$signed({1'b0, lin_c}) : $signed({1'b0, lin_c});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q    <= 40'(33'(in_data_i.target_x) - 33'(in_data_i.robot_x));
      y_q    <= 40'(33'(in_data_i.target_y) - 33'(in_data_i.robot_y));
      z_q    <= th0;
      rot_q  <= in_data_i.rotate_only;
      rerr_q <= rerr_w[15:0];
    end else if (cmd_i.pre_rot) begin
      if (z_q > HALF_PI_Q) begin
        x_q <= -y_q;
        y_q <= x_q;
        z_q <= z_q - HALF_PI_Q;
      end else if (z_q < -HALF_PI_Q) begin
        x_q <= y_q;
        y_q <= -x_q;
        z_q <= z_q + HALF_PI_Q;
      end
    end else if (cmd_i.rot_step) begin
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end else if (cmd_i.vec_init) begin
      near_q <= near_w;
      fwd_q  <= near_w ? (y_q >= 0) : (x_q >= 0);
      z_q    <= '0;
      if (x_q < 0) begin
        x_q <= -x_q;
        y_q <= -y_q;
      end
    end else if (cmd_i.vec_step) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end else if (cmd_i.wb_x) begin
      x_q <= ungain;
    end else if (cmd_i.wb_y) begin
      y_q <= ungain;
    end
    if (cmd_i.wb_dist) begin
      dist_q <= ungain;
      err_q  <= err_w;
      der_q  <= 17'(err_w) - 17'(prev_q);
    end
    if (cmd_i.mul_en) begin
      p_q <= mul_a * mul_b;
    end
    if (cmd_i.acc_load) begin
      acc_q <= 52'(p_q);
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + 52'(p_q);
    end
    if (cmd_i.load_out) begin
      out_q.angular_speed <= ang_o;
      out_q.linear_speed  <= lin_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q      <= '0;
      int_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.rot_step || cmd_i.vec_step) begin
        iter_q <= (iter_q == ITER_W'(CORDIC_STEPS - 1)) ? '0 : iter_q + 1'b1;
      end
      if (cmd_i.wb_dist) begin
        int_q  <= int_w;
        prev_q <= err_w;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.iter_last = (iter_q == ITER_W'(CORDIC_STEPS - 1));
  assign status_o.out_full  = out_valid_q & ~out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

endmodule

`default_nettype wire
